// ===== design/nma_pkg.sv =====
// Shared types, constants and activation lookup tables for the neuron MAC block.
// No dependencies; every other design file refers to it by scoped names.

package nma_pkg;

    // Fixed-point format and datapath sizes
    localparam int FRAC_BITS     = 8;
    localparam int ACC_WIDTH     = 40;
    localparam int TABLE_ENTRIES = 1024;
    localparam int TBL_IDX_W     = $clog2(TABLE_ENTRIES);
    localparam int DATA_W        = 16;
    localparam int SLOPE_W       = 8;
    localparam int SEL_W         = 2;
    localparam int CFG_IDX_W     = 2;

    // Queue between front and back
    localparam int MQ_DEPTH = 8;
    localparam int MQ_PTR_W = $clog2(MQ_DEPTH);
    localparam int MQ_CNT_W = $clog2(MQ_DEPTH + 1);

    // Activation codes
    localparam logic [SEL_W-1:0] ACT_SIGMOID = 2'd0;
    localparam logic [SEL_W-1:0] ACT_TANH    = 2'd1;
    localparam logic [SEL_W-1:0] ACT_RELU    = 2'd2;
    localparam logic [SEL_W-1:0] ACT_LEAKY   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_SEL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAKY_SLOPE = 2'd2;

    typedef logic signed [ACC_WIDTH-1:0] t_acc;

    typedef struct packed {
        logic signed [DATA_W-1:0] bias;
        logic [SEL_W-1:0]         act_sel;
        logic [SLOPE_W-1:0]       leaky_slope;
    } t_cfg;

    typedef struct packed {
        logic                empty;
        logic [MQ_CNT_W-1:0] count;
    } t_q_stat;

    typedef logic [TABLE_ENTRIES-1:0][DATA_W-1:0] t_tbl;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // Divide a series term by its index (indexes 1 to 24)
    function automatic logic [63:0] div_by_k(input logic [63:0] v, input int k);
        logic [63:0] q;
        case (k)
            1:  q = v;
            2:  q = v / 64'd2;
            3:  q = v / 64'd3;
            4:  q = v / 64'd4;
            5:  q = v / 64'd5;
            6:  q = v / 64'd6;
            7:  q = v / 64'd7;
            8:  q = v / 64'd8;
            9:  q = v / 64'd9;
            10: q = v / 64'd10;
            11: q = v / 64'd11;
            12: q = v / 64'd12;
            13: q = v / 64'd13;
            14: q = v / 64'd14;
            15: q = v / 64'd15;
            16: q = v / 64'd16;
            17: q = v / 64'd17;
            18: q = v / 64'd18;
            19: q = v / 64'd19;
            20: q = v / 64'd20;
            21: q = v / 64'd21;
            22: q = v / 64'd22;
            23: q = v / 64'd23;
            24: q = v / 64'd24;
            default: q = v;
        endcase
        return q;
    endfunction

    // Restoring long division; used only while the tables are built
    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], n[i]};
            if (r >= d) begin
                r    = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^-a in Q30: series of e^-(a/32), then five squarings
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] a);
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] e;
        y = a >> 5;
        if (y > Q30_ONE) y = Q30_ONE;
        term = Q30_ONE;
        pos  = Q30_ONE;
        neg  = '0;
        for (int k = 1; k <= 24; k++) begin
            term = div_by_k((term * y) >> 30, k);
            if (k[0]) neg = neg + term;
            else      pos = pos + term;
        end
        e = (pos > neg) ? pos - neg : 64'd0;
        if (e > Q30_ONE) e = Q30_ONE;
        for (int k = 0; k < 5; k++) e = (e * e) >> 30;
        return e;
    endfunction

    // Build the sigmoid table, or the tanh table when is_tanh is set
    function automatic t_tbl tbl_init(input logic is_tanh);
        t_tbl        t;
        longint      d;
        logic [63:0] mag;
        logic [63:0] a;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] q;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            d   = 16 * longint'(k) - 8 * longint'(TABLE_ENTRIES);
            mag = (d < 0) ? 64'(-d) : 64'(d);
            a   = (mag << 30) / TABLE_ENTRIES;
            if (is_tanh) begin
                e    = exp_neg_q30(a << 1);
                den  = Q30_ONE + e;
                q    = udiv(((Q30_ONE - e) << FRAC_BITS) + (den >> 1), den);
                t[k] = (d >= 0) ? DATA_W'(q) : DATA_W'(64'd0 - q);
            end else begin
                e    = exp_neg_q30(a);
                den  = Q30_ONE + e;
                q    = udiv((64'd1 << (FRAC_BITS + 30)) + (den >> 1), den);
                t[k] = (d >= 0) ? DATA_W'(q) : DATA_W'((64'd1 << FRAC_BITS) - q);
            end
        end
        return t;
    endfunction

    localparam t_tbl SIG_TBL  = tbl_init(1'b0);
    localparam t_tbl TANH_TBL = tbl_init(1'b1);

endpackage

// ===== design/nma_front.sv =====
// Front end: accepts input beats, multiplies, accumulates and adds the bias.
// Depends on nma_pkg; pushes pre-activation values into nma_queue.

module nma_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic signed [nma_pkg::DATA_W-1:0] i_input_value,
    input  logic signed [nma_pkg::DATA_W-1:0] i_weight,
    input  logic                           i_last,
    input  nma_pkg::t_cfg                  i_cfg,
    input  nma_pkg::t_q_stat               i_q_stat,
    output logic                           o_full,
    output logic                           o_q_wr_en,
    output nma_pkg::t_acc                  o_q_wr_data
);

    localparam int AW = nma_pkg::ACC_WIDTH;
    localparam int CW = nma_pkg::MQ_CNT_W + 1;
    localparam nma_pkg::t_acc ACC_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam nma_pkg::t_acc ACC_MIN = {1'b1, {(AW-1){1'b0}}};

    // Clamp a one-bit-wider sum back into the accumulator range
    function automatic nma_pkg::t_acc sat_acc(input logic signed [AW:0] v);
        if (v[AW] != v[AW-1]) return v[AW] ? ACC_MIN : ACC_MAX;
        return v[AW-1:0];
    endfunction

    logic                                   r_s1_v;
    logic signed [nma_pkg::DATA_W-1:0]      r_s1_x;
    logic signed [nma_pkg::DATA_W-1:0]      r_s1_w;
    logic                                   r_s1_last;
    logic                                   r_s2_v;
    logic signed [2*nma_pkg::DATA_W-1:0]    r_s2_prod;
    logic                                   r_s2_last;
    logic                                   r_s3_v;
    nma_pkg::t_acc                          r_s3_sum;
    nma_pkg::t_acc                          r_acc;

    logic                                   accept;
    logic signed [AW:0]                     acc_wide;
    nma_pkg::t_acc                          acc_sat;
    nma_pkg::t_acc                          bias_sh;
    logic signed [AW:0]                     pre_wide;
    logic [CW-1:0]                          pending;

    // Hold off input while the queue could not take every evaluation in flight
    assign pending = CW'(i_q_stat.count) + CW'(r_s1_v & r_s1_last)
                   + CW'(r_s2_v & r_s2_last) + CW'(r_s3_v);
    assign o_full  = pending >= CW'(nma_pkg::MQ_DEPTH);
    assign accept  = i_push & ~o_full;

    // Accumulate with saturation
    assign acc_wide = (AW+1)'(r_acc) + (AW+1)'(r_s2_prod);
    assign acc_sat  = sat_acc(acc_wide);

    // Add the bias aligned to the product format
    assign bias_sh     = nma_pkg::t_acc'(i_cfg.bias) <<< nma_pkg::FRAC_BITS;
    assign pre_wide    = (AW+1)'(r_s3_sum) + (AW+1)'(bias_sh);
    assign o_q_wr_en   = r_s3_v;
    assign o_q_wr_data = sat_acc(pre_wide);

    // Control state and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_acc  <= '0;
        end else begin
            r_s1_v <= accept;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v & r_s2_last;
            if (r_s2_v) begin
                r_acc <= r_s2_last ? '0 : acc_sat;
            end
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_x    <= i_input_value;
            r_s1_w    <= i_weight;
            r_s1_last <= i_last;
        end
        r_s2_prod <= r_s1_x * r_s1_w;
        r_s2_last <= r_s1_last;
        if (r_s2_v) begin
            r_s3_sum <= acc_sat;
        end
    end

endmodule

// ===== design/nma_queue.sv =====
// Short queue of pre-activation values between the front and back ends.
// Depends on nma_pkg.

module nma_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  nma_pkg::t_acc    i_wr_data,
    input  logic             i_rd_en,
    output nma_pkg::t_acc    o_rd_data,
    output nma_pkg::t_q_stat o_stat
);

    localparam int PW = nma_pkg::MQ_PTR_W;
    localparam int NW = nma_pkg::MQ_CNT_W;

    nma_pkg::t_acc   r_mem [nma_pkg::MQ_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [NW-1:0]   r_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(nma_pkg::MQ_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_rd_data    = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (i_rd_en) r_rd_ptr <= ptr_inc(r_rd_ptr);
            r_count <= r_count + NW'(i_wr_en) - NW'(i_rd_en);
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// ===== design/nma_back.sv =====
// Back end: applies the activation and holds finished results for the consumer.
// Depends on nma_pkg (tables, codes); pops pre-activation values from nma_queue.

module nma_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  nma_pkg::t_cfg                     i_cfg,
    input  nma_pkg::t_q_stat                  i_q_stat,
    input  nma_pkg::t_acc                     i_q_rd_data,
    output logic                              o_q_rd_en,
    input  logic                              i_pop,
    output logic                              o_empty,
    output logic signed [nma_pkg::DATA_W-1:0] o_activation_out,
    output logic                              o_saturated
);

    localparam int AW      = nma_pkg::ACC_WIDTH;
    localparam int DW      = nma_pkg::DATA_W;
    localparam int DIFF_W  = 2 * nma_pkg::FRAC_BITS + 4;
    localparam int IPW     = DIFF_W + nma_pkg::TBL_IDX_W + 1;
    localparam int LW      = AW + nma_pkg::SLOPE_W + 1;
    localparam int OUT_DEPTH = 4;
    localparam int OPW     = $clog2(OUT_DEPTH);
    localparam int ONW     = $clog2(OUT_DEPTH + 1);

    localparam nma_pkg::t_acc TBL_LO =
        nma_pkg::t_acc'(-(longint'(8) <<< (2 * nma_pkg::FRAC_BITS)));
    localparam nma_pkg::t_acc TBL_HI =
        nma_pkg::t_acc'((longint'(8) <<< (2 * nma_pkg::FRAC_BITS)) - 1);
    localparam logic signed [LW-1:0] V_MAX = LW'(2**(DW-1) - 1);
    localparam logic signed [LW-1:0] V_MIN = LW'(-(2**(DW-1)));

    // Clip to the output range; the top bit flags a clip
    function automatic logic [DW:0] sat_out(input logic signed [LW-1:0] v);
        if (v > V_MAX) return {1'b1, 1'b0, {(DW-1){1'b1}}};
        if (v < V_MIN) return {1'b1, 1'b1, {(DW-1){1'b0}}};
        return {1'b0, v[DW-1:0]};
    endfunction

    // Stage 1
    logic                             r_b1_v;
    logic [DIFF_W-1:0]                r_b1_diff;
    nma_pkg::t_acc                    r_b1_pre;
    logic signed [LW-1:0]             r_b1_lprod;
    logic [nma_pkg::SEL_W-1:0]        r_b1_sel;
    // Stage 2
    logic                             r_b2_v;
    logic                             r_b2_use_tbl;
    logic [DW-1:0]                    r_b2_tbl;
    logic [DW:0]                      r_b2_lin;
    // Result buffer
    logic [DW:0]                      r_out_mem [OUT_DEPTH];
    logic [OPW-1:0]                   r_out_wr_ptr;
    logic [OPW-1:0]                   r_out_rd_ptr;
    logic [ONW-1:0]                   r_out_count;

    nma_pkg::t_acc                    clip;
    nma_pkg::t_acc                    diff_full;
    logic signed [LW-1:0]             lprod;
    logic [IPW-1:0]                   idx_prod;
    logic [nma_pkg::TBL_IDX_W-1:0]    idx;
    nma_pkg::t_acc                    relu_sh;
    logic signed [LW-1:0]             leaky_sh;
    logic signed [LW-1:0]             lin_val;
    logic                             use_tbl;
    logic [ONW:0]                     out_pend;
    logic                             out_wr;
    logic                             out_rd;
    logic [DW:0]                      out_wr_data;

    function automatic logic [OPW-1:0] ptr_inc(input logic [OPW-1:0] p);
        return (p == OPW'(OUT_DEPTH - 1)) ? '0 : p + OPW'(1);
    endfunction

    // Pop only when the result buffer has room for everything in flight
    assign out_pend  = (ONW+1)'(r_out_count) + (ONW+1)'(r_b1_v) + (ONW+1)'(r_b2_v);
    assign o_q_rd_en = ~i_q_stat.empty & (out_pend < (ONW+1)'(OUT_DEPTH));

    // Clip the table argument to [-8, 8) and offset it to zero
    always_comb begin
        if (i_q_rd_data < TBL_LO)      clip = TBL_LO;
        else if (i_q_rd_data > TBL_HI) clip = TBL_HI;
        else                           clip = i_q_rd_data;
    end
    assign diff_full = clip - TBL_LO;
    assign lprod     = i_q_rd_data * $signed({1'b0, i_cfg.leaky_slope});

    // Table index and linear paths
    assign idx_prod = IPW'(r_b1_diff) * IPW'(nma_pkg::TABLE_ENTRIES);
    assign idx      = idx_prod[DIFF_W +: nma_pkg::TBL_IDX_W];
    assign relu_sh  = r_b1_pre >>> nma_pkg::FRAC_BITS;
    assign leaky_sh = r_b1_lprod >>> (nma_pkg::FRAC_BITS + nma_pkg::SLOPE_W);

    always_comb begin
        use_tbl = 1'b0;
        lin_val = '0;
        case (r_b1_sel) inside
            nma_pkg::ACT_SIGMOID, nma_pkg::ACT_TANH: begin
                use_tbl = 1'b1;
            end
            nma_pkg::ACT_LEAKY: begin
                lin_val = r_b1_pre[AW-1] ? leaky_sh : LW'(relu_sh);
            end
            default: begin
                lin_val = r_b1_pre[AW-1] ? '0 : LW'(relu_sh);
            end
        endcase
    end

    // Pick the result going into the buffer
    assign out_wr      = r_b2_v;
    assign out_rd      = i_pop & ~o_empty;
    assign out_wr_data = r_b2_use_tbl ? {1'b0, r_b2_tbl} : r_b2_lin;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v       <= 1'b0;
            r_b2_v       <= 1'b0;
            r_out_wr_ptr <= '0;
            r_out_rd_ptr <= '0;
            r_out_count  <= '0;
        end else begin
            r_b1_v <= o_q_rd_en;
            r_b2_v <= r_b1_v;
            if (out_wr) r_out_wr_ptr <= ptr_inc(r_out_wr_ptr);
            if (out_rd) r_out_rd_ptr <= ptr_inc(r_out_rd_ptr);
            r_out_count <= r_out_count + ONW'(out_wr) - ONW'(out_rd);
        end
    end

    // Payload stages, table read and result buffer storage
    always_ff @(posedge i_clk) begin
        if (o_q_rd_en) begin
            r_b1_diff  <= diff_full[DIFF_W-1:0];
            r_b1_pre   <= i_q_rd_data;
            r_b1_lprod <= lprod;
            r_b1_sel   <= i_cfg.act_sel;
        end
        r_b2_use_tbl <= use_tbl;
        r_b2_lin     <= sat_out(lin_val);
        r_b2_tbl     <= (r_b1_sel == nma_pkg::ACT_TANH) ? nma_pkg::TANH_TBL[idx]
                                                         : nma_pkg::SIG_TBL[idx];
        if (out_wr) begin
            r_out_mem[r_out_wr_ptr] <= out_wr_data;
        end
    end

    assign o_empty          = (r_out_count == '0);
    assign o_activation_out = r_out_mem[r_out_rd_ptr][DW-1:0];
    assign o_saturated      = r_out_mem[r_out_rd_ptr][DW];

endmodule

// ===== design/neuron_mac_activation_top.sv =====
// Top level of the neuron multiply-accumulate block with selectable activation.
// Depends on nma_pkg, nma_front, nma_queue and nma_back.
//
// One neuron: each input beat (push/full) carries a signed Q8.8 input and weight,
// whose product is added to a saturating 40-bit accumulator. The beat marked last
// closes the evaluation: the bias is added, the selected activation (sigmoid, tanh,
// relu, leaky relu) is applied, and one Q8.8 result with a clip flag is queued on
// the result side (empty/pop); the accumulator then clears. The block takes one
// input beat every cycle while full is low; the accumulate loop, which feeds the
// accumulator back into itself, sets that rate. A result reaches the result ports
// through the multiply, accumulate, bias and queue write, queue read and clip,
// registered 1024-entry table read and result buffer stages. Configuration must be
// written by the user only while no evaluation is open; the block does not enforce it.

module neuron_mac_activation_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [nma_pkg::CFG_IDX_W-1:0]       i_cfg_wr_index,
    input  logic [nma_pkg::DATA_W-1:0]          i_cfg_wr_data,
    input  logic                                push,
    output logic                                full,
    input  logic signed [nma_pkg::DATA_W-1:0]   i_input_value,
    input  logic signed [nma_pkg::DATA_W-1:0]   i_weight,
    input  logic                                i_last,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [nma_pkg::DATA_W-1:0]   o_activation_out,
    output logic                                o_saturated
);

    logic signed [nma_pkg::DATA_W-1:0]  r_bias;
    logic [nma_pkg::SEL_W-1:0]          r_act_sel;
    logic [nma_pkg::SLOPE_W-1:0]        r_leaky_slope;

    nma_pkg::t_cfg     cfg;
    nma_pkg::t_q_stat  q_stat;
    logic              q_wr_en;
    nma_pkg::t_acc     q_wr_data;
    logic              q_rd_en;
    nma_pkg::t_acc     q_rd_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias        <= '0;
            r_act_sel     <= nma_pkg::ACT_SIGMOID;
            r_leaky_slope <= nma_pkg::SLOPE_W'(3);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_wr_index)
                nma_pkg::CFG_BIAS:        r_bias        <= i_cfg_wr_data;
                nma_pkg::CFG_ACT_SEL:     r_act_sel     <= i_cfg_wr_data[nma_pkg::SEL_W-1:0];
                nma_pkg::CFG_LEAKY_SLOPE: r_leaky_slope <= i_cfg_wr_data[nma_pkg::SLOPE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.bias        = r_bias;
    assign cfg.act_sel     = r_act_sel;
    assign cfg.leaky_slope = r_leaky_slope;

    nma_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_input_value (i_input_value),
        .i_weight      (i_weight),
        .i_last        (i_last),
        .i_cfg         (cfg),
        .i_q_stat      (q_stat),
        .o_full        (full),
        .o_q_wr_en     (q_wr_en),
        .o_q_wr_data   (q_wr_data)
    );

    nma_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (q_wr_en),
        .i_wr_data (q_wr_data),
        .i_rd_en   (q_rd_en),
        .o_rd_data (q_rd_data),
        .o_stat    (q_stat)
    );

    nma_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_q_stat         (q_stat),
        .i_q_rd_data      (q_rd_data),
        .o_q_rd_en        (q_rd_en),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_activation_out (o_activation_out),
        .o_saturated      (o_saturated)
    );

endmodule

// ===== dv/tb_neuron_mac_activation_top.sv =====
`timescale 1ns / 100ps

// Testbench for neuron_mac_activation_top: directed and random MAC beats, checked
// against a behavioral neuron with its own activation tables. Depends on nma_pkg.

module tb_neuron_mac_activation_top;

    // Index with no register behind it; writes there must be dropped
    localparam logic [nma_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [nma_pkg::SLOPE_W-1:0]   SLOPE_RESET = 8'd3;
    localparam longint ACC_HI  = (longint'(1) << (nma_pkg::ACC_WIDTH - 1)) - 1;
    localparam longint ACC_LO  = -ACC_HI - 1;
    localparam longint ARG_LO  = -(longint'(8) << (2 * nma_pkg::FRAC_BITS));
    localparam longint ARG_HI  = (longint'(8) << (2 * nma_pkg::FRAC_BITS)) - 1;
    localparam longint OUT_MAX = (longint'(1) << (nma_pkg::DATA_W - 1)) - 1;
    localparam longint OUT_MIN = -OUT_MAX - 1;
    localparam bit [63:0] Q30  = 64'd1 << 30;
    localparam int RANDOM_BEATS = 400;

    typedef struct packed {
        logic signed [nma_pkg::DATA_W-1:0] act;
        logic                              sat;
    } t_neuron_out;

    // Behavioral neuron plus the queue of outputs it still owes
    class neuron_tracker;
        int                                sig_lut[nma_pkg::TABLE_ENTRIES];
        int                                tanh_lut[nma_pkg::TABLE_ENTRIES];
        longint                            acc;
        logic signed [nma_pkg::DATA_W-1:0] bias;
        logic [nma_pkg::SEL_W-1:0]         act_sel;
        logic [nma_pkg::SLOPE_W-1:0]       slope;
        t_neuron_out                       owed[$];
        int                                mismatches;

        // e^-a in Q30: truncated series of e^-(a/32), squared five times
        function bit [63:0] decay_q30(bit [63:0] a);
            bit [63:0] y;
            bit [63:0] term;
            bit [63:0] plus;
            bit [63:0] minus;
            bit [63:0] e;
            y = a >> 5;
            if (y > Q30) y = Q30;
            term  = Q30;
            plus  = Q30;
            minus = 64'd0;
            for (int k = 1; k <= 24; k++) begin
                term = ((term * y) >> 30) / 64'(k);
                if (k % 2 == 1) minus += term;
                else plus += term;
            end
            e = (plus > minus) ? plus - minus : 64'd0;
            if (e > Q30) e = Q30;
            repeat (5) e = (e * e) >> 30;
            return e;
        endfunction

        function new();
            longint    d;
            bit [63:0] mag;
            bit [63:0] a;
            bit [63:0] e;
            bit [63:0] den;
            bit [63:0] q;
            for (int k = 0; k < nma_pkg::TABLE_ENTRIES; k++) begin
                d   = 16 * longint'(k) - 8 * longint'(nma_pkg::TABLE_ENTRIES);
                mag = (d < 0) ? 64'(-d) : 64'(d);
                a   = (mag << 30) / 64'(nma_pkg::TABLE_ENTRIES);
                // sigmoid, mirrored about one half on the negative side
                e   = decay_q30(a);
                den = Q30 + e;
                q   = ((64'd1 << (nma_pkg::FRAC_BITS + 30)) + den / 2) / den;
                sig_lut[k] = (d >= 0) ? int'(q) : (1 << nma_pkg::FRAC_BITS) - int'(q);
                // tanh, odd symmetry
                e   = decay_q30(a << 1);
                den = Q30 + e;
                q   = (((Q30 - e) << nma_pkg::FRAC_BITS) + den / 2) / den;
                tanh_lut[k] = (d >= 0) ? int'(q) : -int'(q);
            end
            acc        = 0;
            bias       = '0;
            act_sel    = nma_pkg::ACT_SIGMOID;
            slope      = SLOPE_RESET;
            mismatches = 0;
        endfunction

        function longint clip_acc(longint v);
            if (v > ACC_HI) return ACC_HI;
            if (v < ACC_LO) return ACC_LO;
            return v;
        endfunction

        function void write_reg(logic [nma_pkg::CFG_IDX_W-1:0] idx,
                                logic [nma_pkg::DATA_W-1:0] data);
            case (idx)
                nma_pkg::CFG_BIAS:        bias = data;
                nma_pkg::CFG_ACT_SEL:     act_sel = data[nma_pkg::SEL_W-1:0];
                nma_pkg::CFG_LEAKY_SLOPE: slope = data[nma_pkg::SLOPE_W-1:0];
                default: ;
            endcase
        endfunction

        // Accumulate one beat; on the closing beat queue the activation
        function void take_beat(logic signed [nma_pkg::DATA_W-1:0] x,
                                logic signed [nma_pkg::DATA_W-1:0] w,
                                logic is_last);
            longint      pre;
            longint      y;
            longint      idx;
            t_neuron_out r;
            acc = clip_acc(acc + longint'(x) * longint'(w));
            if (!is_last) return;
            pre = clip_acc(acc + (longint'(bias) <<< nma_pkg::FRAC_BITS));
            acc = 0;
            if (act_sel == nma_pkg::ACT_SIGMOID || act_sel == nma_pkg::ACT_TANH) begin
                if (pre < ARG_LO) pre = ARG_LO;
                if (pre > ARG_HI) pre = ARG_HI;
                idx = ((pre - ARG_LO) * nma_pkg::TABLE_ENTRIES)
                      >>> (2 * nma_pkg::FRAC_BITS + 4);
                if (idx >= nma_pkg::TABLE_ENTRIES) idx = nma_pkg::TABLE_ENTRIES - 1;
                y = (act_sel == nma_pkg::ACT_SIGMOID) ? sig_lut[idx] : tanh_lut[idx];
            end else if (pre >= 0) begin
                y = pre >>> nma_pkg::FRAC_BITS;
            end else if (act_sel == nma_pkg::ACT_LEAKY) begin
                y = (pre * longint'(slope)) >>> (nma_pkg::FRAC_BITS + 8);
            end else begin
                y = 0;
            end
            r.sat = (y > OUT_MAX || y < OUT_MIN);
            if (y > OUT_MAX) y = OUT_MAX;
            else if (y < OUT_MIN) y = OUT_MIN;
            r.act = nma_pkg::DATA_W'(y);
            owed = {owed, r};
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%0t: mismatch: %s", $realtime, msg);
        endfunction

        function void check_output(logic signed [nma_pkg::DATA_W-1:0] act, logic sat);
            t_neuron_out want;
            if (owed.size() == 0) begin
                flag($sformatf("output act=%0d sat=%0b with nothing owed", act, sat));
                return;
            end
            want = owed.pop_front();
            if (act !== want.act || sat !== want.sat)
                flag($sformatf("act expected %0d got %0d, sat expected %0b got %0b",
                               want.act, act, want.sat, sat));
        endfunction

        function int outstanding();
            return owed.size();
        endfunction
    endclass

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 i_cfg_wr_en;
    logic [nma_pkg::CFG_IDX_W-1:0]        i_cfg_wr_index;
    logic [nma_pkg::DATA_W-1:0]           i_cfg_wr_data;
    logic                                 push;
    logic                                 full;
    logic signed [nma_pkg::DATA_W-1:0]    i_input_value;
    logic signed [nma_pkg::DATA_W-1:0]    i_weight;
    logic                                 i_last;
    logic                                 empty;
    logic                                 pop;
    logic signed [nma_pkg::DATA_W-1:0]    o_activation_out;
    logic                                 o_saturated;

    neuron_tracker board;
    int snd_idle_pct = 9;
    int rcv_idle_pct = 52;

    neuron_mac_activation_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_index   (i_cfg_wr_index),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .push             (push),
        .full             (full),
        .i_input_value    (i_input_value),
        .i_weight         (i_weight),
        .i_last           (i_last),
        .empty            (empty),
        .pop              (pop),
        .o_activation_out (o_activation_out),
        .o_saturated      (o_saturated)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Receiver: random pop stalls, changed on the falling edge
    initial begin
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            pop = ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && pop && !empty)
            board.check_output(o_activation_out, o_saturated);
    end

    // Small Q8.8 values in 7 of 16 picks so the tables see their interior; full range or extremes otherwise
    function automatic logic [nma_pkg::DATA_W-1:0] pick_sample();
        int v;
        case ($urandom_range(15))
            0:                   v = -32768;
            1:                   v = 32767;
            2:                   v = 0;
            3, 4, 5, 6, 7, 8, 9: v = int'($urandom_range(2048)) - 1024;
            default:             v = int'($urandom_range(65535)) - 32768;
        endcase
        return nma_pkg::DATA_W'(v);
    endfunction

    // Offer one beat; hold push across back-to-back beats
    task automatic send_beat(logic [nma_pkg::DATA_W-1:0] x, logic [nma_pkg::DATA_W-1:0] w,
                             logic is_last);
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push          = 1'b1;
        i_input_value = x;
        i_weight      = w;
        i_last        = is_last;
        do @(posedge i_clk); while (full);
        board.take_beat(x, w, is_last);
    endtask

    task automatic write_cfg(logic [nma_pkg::CFG_IDX_W-1:0] idx,
                             logic [nma_pkg::DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en    = 1'b1;
        i_cfg_wr_index = idx;
        i_cfg_wr_data  = data;
        @(posedge i_clk);
        board.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // Drop push, wait for every owed output, then let the pipeline empty
    task automatic settle();
        @(negedge i_clk);
        push = 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // New register settings with junk in the unused high bits
    task automatic program_random_config();
        logic [nma_pkg::DATA_W-1:0] b;
        logic [nma_pkg::SLOPE_W-1:0] s;
        case ($urandom_range(7))
            0:       b = 16'h8000;
            1:       b = 16'h7FFF;
            2, 3, 4: b = nma_pkg::DATA_W'(int'($urandom_range(4096)) - 2048);
            default: b = nma_pkg::DATA_W'($urandom);
        endcase
        case ($urandom_range(5))
            0:       s = '0;
            1:       s = '1;
            default: s = nma_pkg::SLOPE_W'($urandom);
        endcase
        write_cfg(nma_pkg::CFG_ACT_SEL, {14'($urandom), nma_pkg::SEL_W'($urandom_range(3))});
        write_cfg(nma_pkg::CFG_BIAS, b);
        write_cfg(nma_pkg::CFG_LEAKY_SLOPE, {8'($urandom), s});
        if ($urandom_range(3) == 0) write_cfg(CFG_SPARE, nma_pkg::DATA_W'($urandom));
    endtask

    initial begin
        int beats_sent;
        int len;
        board          = new();
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_index = '0;
        i_cfg_wr_data  = '0;
        push           = 1'b0;
        i_input_value  = '0;
        i_weight       = '0;
        i_last         = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Settings after reset: sigmoid, zero bias
        send_beat(16'h0000, 16'h0000, 1'b1);
        send_beat(16'h7FFF, 16'h7FFF, 1'b1);   // argument clipped high
        send_beat(16'h8000, 16'h7FFF, 1'b1);   // argument clipped low
        send_beat(16'h0100, 16'h0200, 1'b0);
        send_beat(16'hFF00, 16'h0080, 1'b1);
        settle();

        // tanh
        write_cfg(nma_pkg::CFG_ACT_SEL, {14'h1555, nma_pkg::ACT_TANH});
        send_beat(16'h0100, 16'h0100, 1'b1);
        send_beat(16'h8000, 16'h8000, 1'b1);
        send_beat(16'hFF00, 16'h0100, 1'b1);
        settle();

        // relu with largest bias: clip high, negative side, clip high again
        write_cfg(nma_pkg::CFG_ACT_SEL, {14'h0000, nma_pkg::ACT_RELU});
        write_cfg(nma_pkg::CFG_BIAS, 16'h7FFF);
        send_beat(16'h7FFF, 16'h7FFF, 1'b1);
        send_beat(16'h8000, 16'h7FFF, 1'b1);
        send_beat(16'h0100, 16'h0100, 1'b1);
        settle();

        // leaky with smallest bias and steepest slope: clip low and high
        write_cfg(nma_pkg::CFG_BIAS, 16'h8000);
        write_cfg(nma_pkg::CFG_ACT_SEL, {14'h3FFF, nma_pkg::ACT_LEAKY});
        write_cfg(nma_pkg::CFG_LEAKY_SLOPE, 16'hC3FF);
        send_beat(16'h8000, 16'h7FFF, 1'b1);
        send_beat(16'h7FFF, 16'h7FFF, 1'b1);
        settle();

        // leaky with zero slope, then the reset slope on a tiny negative sum
        write_cfg(nma_pkg::CFG_LEAKY_SLOPE, 16'h0000);
        write_cfg(nma_pkg::CFG_BIAS, 16'h0000);
        write_cfg(CFG_SPARE, 16'hFFFF);
        send_beat(16'hFFFF, 16'h0001, 1'b1);
        settle();
        write_cfg(nma_pkg::CFG_LEAKY_SLOPE, {8'h00, SLOPE_RESET});
        send_beat(16'hFFFF, 16'h0001, 1'b1);
        settle();

        // Random evaluations; idle pattern moves through three stretches
        beats_sent = 0;
        while (beats_sent < RANDOM_BEATS) begin
            if (beats_sent < RANDOM_BEATS / 3) begin
                snd_idle_pct = 9;
                rcv_idle_pct = 52;
            end else if (beats_sent < 2 * RANDOM_BEATS / 3) begin
                snd_idle_pct = 52;
                rcv_idle_pct = 9;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            program_random_config();
            repeat ($urandom_range(2, 6)) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
                for (int i = 1; i <= len; i++)
                    send_beat(pick_sample(), pick_sample(), i == len);
                beats_sent += len;
            end
            settle();
        end

        repeat (20) @(posedge i_clk);
        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
